// File: hw/rtl/summed_area_table_builder_core_macros.svh
// assertion macros for the summed area table builder checker
`ifndef SUMMED_AREA_TABLE_BUILDER_CORE_MACROS_SVH
`define SUMMED_AREA_TABLE_BUILDER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SATB_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SATB_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: hw/rtl/satb_pkg.sv
// shared types and constants for the summed area table builder
package satb_pkg;

	localparam int VALUE_W   = 36;
	localparam int RUN_SUM_W = 26;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_RESET = 1024;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b1;

	typedef struct packed {
		logic first_row;
		logic row_end;
		logic frame_end;
	} satb_flags_t;

endpackage

// File: hw/rtl/summed_area_table_builder_core.sv
// top level of the summed area table builder
//
//  channel   direction  handshake           payload
//  input     in         push / full         sample
//  result    out        pop / empty         table_value, row_end, frame_end
//  config    in         cfg_write           cfg_index, cfg_data
//
// one sample per cycle sustained while results are popped; a request passes through the middle
// queue and the registered line store read, then the add and write-back, into the output queue.
// the line store has one write and one registered read per cycle; a read of the
// column written in the same cycle is forwarded, so a one-column row also runs at full rate.
// reset clears counters, running sum and queues; the line store is never cleared.
// a stalled output fills the result queue, then the middle queue, then raises full.
module summed_area_table_builder_core #(
	parameter int MAX_COLUMNS  = 1024,
	parameter int MAX_ROWS     = 1024,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [satb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [satb_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [satb_pkg::VALUE_W-1:0] table_value,
	output logic                                row_end,
	output logic                                frame_end
);
	import satb_pkg::*;

	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int RUN_W = ((SAMPLE_WIDTH > RUN_SUM_W) ? SAMPLE_WIDTH : RUN_SUM_W) + 1;
	localparam int FLG_W = $bits(satb_flags_t);
	localparam int MID_W = RUN_W + COL_W + FLG_W;
	localparam int OUT_W = VALUE_W + 2;

	logic                 f_push;
	logic [RUN_W-1:0]     f_run;
	logic [COL_W-1:0]     f_col;
	satb_flags_t          f_flags;
	logic                 mid_full;
	logic                 mid_empty;
	logic                 mid_pop;
	logic [MID_W-1:0]     mid_rdata;
	satb_flags_t          b_flags;
	logic                 o_full;
	logic                 o_push;
	logic [VALUE_W-1:0]   o_value;
	logic                 o_row_end;
	logic                 o_frame_end;
	logic [OUT_W-1:0]     out_rdata;

	satb_front #(
		.MAX_COLUMNS  (MAX_COLUMNS),
		.MAX_ROWS     (MAX_ROWS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COL_W        (COL_W),
		.RUN_W        (RUN_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.sample    (sample),
		.q_full    (mid_full),
		.q_push    (f_push),
		.q_run     (f_run),
		.q_col     (f_col),
		.q_flags   (f_flags)
	);

	satb_queue #(
		.WIDTH (MID_W),
		.DEPTH (4)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.wr_data ({f_run, f_col, f_flags}),
		.full    (mid_full),
		.pop     (mid_pop),
		.rd_data (mid_rdata),
		.empty   (mid_empty)
	);

	assign b_flags = mid_rdata[FLG_W-1:0];

	satb_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.COL_W       (COL_W),
		.RUN_W       (RUN_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (mid_empty),
		.q_pop       (mid_pop),
		.q_run       (mid_rdata[MID_W-1 -: RUN_W]),
		.q_col       (mid_rdata[FLG_W +: COL_W]),
		.q_flags     (b_flags),
		.o_full      (o_full),
		.o_push      (o_push),
		.o_value     (o_value),
		.o_row_end   (o_row_end),
		.o_frame_end (o_frame_end)
	);

	satb_queue #(
		.WIDTH (OUT_W),
		.DEPTH (2)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (o_push),
		.wr_data ({o_value, o_row_end, o_frame_end}),
		.full    (o_full),
		.pop     (pop),
		.rd_data (out_rdata),
		.empty   (empty)
	);

	assign full        = mid_full;
	assign table_value = out_rdata[OUT_W-1 -: VALUE_W];
	assign row_end     = out_rdata[1];
	assign frame_end   = out_rdata[0];
endmodule

// File: hw/rtl/satb_queue.sv
// small first-in first-out queue built from flip-flops
module satb_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end
endmodule

// File: hw/rtl/satb_front.sv
// front end: length registers, position counters and the row running sum
module satb_front #(
	parameter int MAX_COLUMNS  = 1024,
	parameter int MAX_ROWS     = 1024,
	parameter int SAMPLE_WIDTH = 16,
	parameter int COL_W        = 10,
	parameter int RUN_W        = 27
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [satb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [satb_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              push,
	input  logic signed [SAMPLE_WIDTH-1:0]    sample,
	input  logic                              q_full,
	output logic                              q_push,
	output logic signed [RUN_W-1:0]           q_run,
	output logic [COL_W-1:0]                  q_col,
	output satb_pkg::satb_flags_t             q_flags
);
	import satb_pkg::*;

	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int CLEN_W   = ($clog2(MAX_COLUMNS + 1) > CFG_W) ? $clog2(MAX_COLUMNS + 1) : CFG_W;
	localparam int RLEN_W   = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
	localparam int RST_COLS = (MAX_COLUMNS < CFG_RESET) ? MAX_COLUMNS : CFG_RESET;
	localparam int RST_ROWS = (MAX_ROWS < CFG_RESET) ? MAX_ROWS : CFG_RESET;

	logic [CLEN_W-1:0]          cols_q;
	logic [RLEN_W-1:0]          rows_q;
	logic [COL_W-1:0]           col_q;
	logic [ROW_W-1:0]           row_q;
	logic signed [RUN_SUM_W-1:0] row_sum_q;

	logic [CLEN_W-1:0]  cols_raw;
	logic [RLEN_W-1:0]  rows_raw;
	logic [CLEN_W-1:0]  cols_clamped;
	logic [RLEN_W-1:0]  rows_clamped;
	logic               accept;
	logic               last_col;
	logic               last_row;
	logic [RUN_W-1:0]   sample_ext;
	logic [RUN_W-1:0]   row_sum_ext;
	logic [RUN_W-1:0]   run;

	// zero acts as one, anything beyond the maximum saturates
	assign cols_raw     = CLEN_W'(cfg_data);
	assign rows_raw     = RLEN_W'(cfg_data);
	assign cols_clamped = (cols_raw == '0) ? CLEN_W'(1) :
		(cols_raw > CLEN_W'(MAX_COLUMNS)) ? CLEN_W'(MAX_COLUMNS) : cols_raw;
	assign rows_clamped = (rows_raw == '0) ? RLEN_W'(1) :
		(rows_raw > RLEN_W'(MAX_ROWS)) ? RLEN_W'(MAX_ROWS) : rows_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CLEN_W'(RST_COLS);
			rows_q <= RLEN_W'(RST_ROWS);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROW_LENGTH: cols_q <= cols_clamped;
				REG_FRAME_ROWS: rows_q <= rows_clamped;
				default: ;
			endcase
		end
	end

	assign accept   = push && !q_full;
	// a position at or past the last one counts as last, so a shrunk length wraps at once
	assign last_col = ({1'b0, CLEN_W'(col_q)} + 1'b1) >= {1'b0, cols_q};
	assign last_row = ({1'b0, RLEN_W'(row_q)} + 1'b1) >= {1'b0, rows_q};

	assign sample_ext  = {{(RUN_W - SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
	assign row_sum_ext = {{(RUN_W - RUN_SUM_W){row_sum_q[RUN_SUM_W-1]}}, row_sum_q};
	assign run         = (col_q == '0) ? sample_ext : row_sum_ext + sample_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			row_sum_q <= '0;
		end else if (accept) begin
			row_sum_q <= run[RUN_SUM_W-1:0];
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	assign q_push            = accept;
	assign q_run             = run;
	assign q_col             = col_q;
	assign q_flags.first_row = (row_q == '0);
	assign q_flags.row_end   = last_col;
	assign q_flags.frame_end = last_col && last_row;
endmodule

// File: hw/rtl/satb_back.sv
// back end: line store read, add of the value above, line store write-back
module satb_back #(
	parameter int MAX_COLUMNS = 1024,
	parameter int COL_W       = 10,
	parameter int RUN_W       = 27
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	output logic                                q_pop,
	input  logic signed [RUN_W-1:0]             q_run,
	input  logic [COL_W-1:0]                    q_col,
	input  satb_pkg::satb_flags_t               q_flags,
	input  logic                                o_full,
	output logic                                o_push,
	output logic signed [satb_pkg::VALUE_W-1:0] o_value,
	output logic                                o_row_end,
	output logic                                o_frame_end
);
	import satb_pkg::*;

	logic [VALUE_W-1:0] line_q [MAX_COLUMNS];

	logic               v_s1;
	logic [RUN_W-1:0]   run_s1;
	logic [COL_W-1:0]   col_s1;
	satb_flags_t        flags_s1;
	logic [VALUE_W-1:0] rd_s1;
	logic               fwd_sel_s1;
	logic [VALUE_W-1:0] fwd_val_s1;

	logic               fire;
	logic               load;
	logic [VALUE_W-1:0] above;
	logic [VALUE_W-1:0] value;

	assign fire  = v_s1 && !o_full;
	assign load  = !q_empty && (!v_s1 || fire);
	assign q_pop = load;

	// the entry being written this cycle is newer than what the store returns
	assign above = flags_s1.first_row ? '0 : (fwd_sel_s1 ? fwd_val_s1 : rd_s1);
	assign value = above + {{(VALUE_W - RUN_W){run_s1[RUN_W-1]}}, run_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_s1     <= q_run;
			col_s1     <= q_col;
			flags_s1   <= q_flags;
			fwd_sel_s1 <= fire && (col_s1 == q_col);
			fwd_val_s1 <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			line_q[col_s1] <= value;
		end
		if (load) begin
			rd_s1 <= line_q[q_col];
		end
	end

	assign o_push      = fire;
	assign o_value     = value;
	assign o_row_end   = flags_s1.row_end;
	assign o_frame_end = flags_s1.frame_end;
endmodule

// File: hw/rtl/satb_checker.sv
// port checker for the summed area table builder, with its bind
`include "summed_area_table_builder_core_macros.svh"

module satb_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                push,
	input logic                                full,
	input logic                                empty,
	input logic                                pop,
	input logic signed [satb_pkg::VALUE_W-1:0] table_value,
	input logic                                row_end,
	input logic                                frame_end
);
	import satb_pkg::*;

	// requests taken but not yet popped
	logic [3:0] inflight_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = push && !full;
	assign out_take = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_take && !out_take) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_take && !in_take) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	`SATB_ASSERT_NOW(a_no_invented_result, inflight_q == 4'd0, empty, "result with no request")
	`SATB_ASSERT_NOW(a_full_needs_work, full, inflight_q != 4'd0, "full with nothing in flight")
	`SATB_ASSERT_NOW(a_frame_end_row_end, !empty && frame_end, row_end, "frame end off row end")
	`SATB_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(table_value), "result dropped")
endmodule

bind summed_area_table_builder_core satb_checker u_satb_checker (.*);

// File: tb/sv/testbench.sv
// self-checking testbench for the summed area table builder core
module testbench;
	import satb_pkg::*;

	localparam int COLUMN_LIMIT = 1024;
	localparam int ROW_LIMIT    = 1024;
	localparam int RANDOM_ITEMS = 1900;

	typedef enum logic [1:0] {STEP_SAMPLE, STEP_WRITE} step_kind_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      row_end;
		logic                      frame_end;
	} sum_result_t;

	typedef struct packed {
		step_kind_t                kind;
		logic [CFG_IDX_W-1:0]      idx;
		logic [CFG_W-1:0]          data;
		logic signed [15:0]        smp;
		logic                      typed;
		logic signed [VALUE_W-1:0] value;
		logic                      row_end;
		logic                      frame_end;
	} step_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_write;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]          cfg_data;
	logic                      push;
	logic                      full;
	logic signed [15:0]        sample;
	logic                      empty;
	logic                      pop = 1'b0;
	logic signed [VALUE_W-1:0] table_value;
	logic                      row_end;
	logic                      frame_end;

	// predictor state
	logic signed [VALUE_W-1:0]   line_above [COLUMN_LIMIT];
	bit                          ever_written [COLUMN_LIMIT];
	logic signed [RUN_SUM_W-1:0] run_sum = '0;
	int unsigned                 col_pos = 0;
	int unsigned                 row_pos = 0;
	logic [CFG_W-1:0]            len_reg = CFG_RESET;
	logic [CFG_W-1:0]            rows_reg = CFG_RESET;

	sum_result_t pending_sums [$];
	int          errors = 0;
	bit          calm = 1'b0;
	bit          use_typed = 1'b0;
	sum_result_t typed_sum;

	step_t directed_steps [25] = '{
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sd32767, 1'b1, 36'sd32767, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sh8000, 1'b1, -36'sd1, 1'b0, 1'b0},
		// zero lengths act as one, the current column is past the end
		'{STEP_WRITE, REG_ROW_LENGTH, 11'd0, 16'sd0, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_WRITE, REG_FRAME_ROWS, 11'd0, 16'sd0, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sd5, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sh8000, 1'b1, -36'sd32768, 1'b1, 1'b1},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sh7fff, 1'b1, 36'sd32767, 1'b1, 1'b1},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sh0000, 1'b1, 36'sd0, 1'b1, 1'b1},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'shffff, 1'b1, -36'sd1, 1'b1, 1'b1},
		// single column, three rows: a column sum
		'{STEP_WRITE, REG_FRAME_ROWS, 11'd3, 16'sd0, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sh7fff, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sh7fff, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sh7fff, 1'b0, 36'sd0, 1'b0, 1'b0},
		// oversized lengths saturate
		'{STEP_WRITE, REG_ROW_LENGTH, 11'd2047, 16'sd0, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_WRITE, REG_FRAME_ROWS, 11'd2047, 16'sd0, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sd100, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, -16'sd200, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sd300, 1'b0, 36'sd0, 1'b0, 1'b0},
		// shrink mid-row: wraps at once
		'{STEP_WRITE, REG_ROW_LENGTH, 11'd2, 16'sd0, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sd7, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sd1, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sd2, 1'b0, 36'sd0, 1'b0, 1'b0},
		// fewer rows mid-frame: current row becomes the last one
		'{STEP_WRITE, REG_FRAME_ROWS, 11'd2, 16'sd0, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sd3, 1'b0, 36'sd0, 1'b0, 1'b0},
		'{STEP_SAMPLE, REG_ROW_LENGTH, 11'd0, 16'sd4, 1'b0, 36'sd0, 1'b0, 1'b0}
	};

	summed_area_table_builder_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.sample      (sample),
		.empty       (empty),
		.pop         (pop),
		.table_value (table_value),
		.row_end     (row_end),
		.frame_end   (frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 300000);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int unsigned clamp_len(input logic [CFG_W-1:0] v, input int unsigned limit);
		if (v == 0) return 1;
		if (v > limit) return limit;
		return v;
	endfunction

	// a longer row mid-frame must not read line store entries never written
	function automatic bit row_length_safe(input logic [CFG_W-1:0] v);
		if (row_pos == 0) return 1'b1;
		for (int i = 0; i < clamp_len(v, COLUMN_LIMIT); i++)
			if (!ever_written[i]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic sum_result_t advance_table(input logic signed [15:0] s);
		sum_result_t               r;
		logic signed [VALUE_W-1:0] wide_s, run_prev, run_wide, above;
		int unsigned               cols, rows, idx;
		logic                      last_col, last_row;
		cols = clamp_len(len_reg, COLUMN_LIMIT);
		rows = clamp_len(rows_reg, ROW_LIMIT);
		idx = (col_pos >= COLUMN_LIMIT) ? COLUMN_LIMIT - 1 : col_pos;
		wide_s = s;
		run_prev = run_sum;
		run_wide = (col_pos == 0) ? wide_s : run_prev + wide_s;
		above = (row_pos == 0) ? '0 : line_above[idx];
		r.value = above + run_wide;
		line_above[idx] = r.value;
		ever_written[idx] = 1'b1;
		run_sum = run_wide[RUN_SUM_W-1:0];
		last_col = (col_pos + 1 >= cols);
		last_row = (row_pos + 1 >= rows);
		r.row_end = last_col;
		r.frame_end = last_col && last_row;
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (errors < 100)
			$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	// requests are accepted and results checked at the rising edge
	always @(posedge clk) begin
		sum_result_t got, want;
		if (arst_n && pop && !empty) begin
			if (pending_sums.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", table_value));
			end else begin
				want = pending_sums.pop_front();
				if (table_value !== want.value)
					report_mismatch($sformatf("table_value %0d, expected %0d",
						table_value, want.value));
				if (row_end !== want.row_end)
					report_mismatch($sformatf("row_end %b, expected %b",
						row_end, want.row_end));
				if (frame_end !== want.frame_end)
					report_mismatch($sformatf("frame_end %b, expected %b",
						frame_end, want.frame_end));
			end
		end
		if (arst_n && push && !full) begin
			got = advance_table(sample);
			pending_sums.push_back(use_typed ? typed_sum : got);
		end
	end

	always @(negedge clk) begin
		pop <= arst_n && (calm || $urandom_range(99) >= 16);
	end

	task automatic send_sample(input logic signed [15:0] s);
		while (!calm && $urandom_range(99) < 16) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		sample <= s;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic drain_block;
		push <= 1'b0;
		while (pending_sums.size() != 0) @(negedge clk);
		// results trail their request through the queues and the line store read register
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		if (idx == REG_ROW_LENGTH) len_reg = data;
		else rows_reg = data;
	endtask

	initial begin
		int unsigned        burst;
		int unsigned        rand_sent;
		logic [CFG_W-1:0]   new_len;
		logic signed [15:0] s;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		sample = '0;
		rand_sent = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_WRITE) begin
				drain_block();
				write_reg(directed_steps[i].idx, directed_steps[i].data);
			end else begin
				use_typed = directed_steps[i].typed;
				typed_sum = '{directed_steps[i].value, directed_steps[i].row_end,
					directed_steps[i].frame_end};
				send_sample(directed_steps[i].smp);
			end
		end
		use_typed = 1'b0;

		while (rand_sent < RANDOM_ITEMS) begin
			drain_block();
			if ($urandom_range(2) != 0) begin
				case ($urandom_range(9))
					0: new_len = 0;
					1: new_len = 1;
					2: new_len = COLUMN_LIMIT;
					3: new_len = CFG_W'($urandom_range(2047, COLUMN_LIMIT + 1));
					4: new_len = 2047;
					default: new_len = CFG_W'($urandom_range(40, 2));
				endcase
				if (row_length_safe(new_len))
					write_reg(REG_ROW_LENGTH, new_len);
			end
			if ($urandom_range(2) != 0) begin
				case ($urandom_range(9))
					0: new_len = 0;
					1: new_len = 1;
					2: new_len = ROW_LIMIT;
					3: new_len = CFG_W'($urandom_range(2047, ROW_LIMIT + 1));
					4: new_len = 2047;
					default: new_len = CFG_W'($urandom_range(12, 2));
				endcase
				write_reg(REG_FRAME_ROWS, new_len);
			end
			burst = $urandom_range(150, 20);
			repeat (burst) begin
				// a stretch of back-to-back traffic on both sides
				calm = (rand_sent >= 700 && rand_sent < 1000);
				case ($urandom_range(15))
					0: s = 16'sh7fff;
					1: s = 16'sh8000;
					2: s = 16'sh0000;
					3: s = 16'shffff;
					default: s = 16'($urandom);
				endcase
				send_sample(s);
				rand_sent++;
			end
		end
		calm = 1'b0;

		push <= 1'b0;
		while (pending_sums.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0 && pending_sums.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
